// File: rtl/sts_pkg.sv
`timescale 1ns / 1ps

package sts_pkg;

   // fixed field widths
   localparam int ANGLE_W = 32;
   localparam int CNT_W   = 4;

   // term magnitude and running sum widths (magnitude capped at 2^62-1)
   localparam int TERM_W = 62;
   localparam int ACC_W  = 63;

   localparam logic [CNT_W-1:0]  TERM_COUNT_RESET = 4'd10;
   localparam logic [TERM_W-1:0] MAG_CAP          = {TERM_W{1'b1}};

   // output clip limits, as acc-width signed values
   localparam logic signed [ACC_W-1:0] ACC_OUT_MAX = 63'sh0000_0000_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = -63'sh0000_0000_8000_0000;

   localparam logic signed [ANGLE_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ANGLE_W-1:0] OUT_MIN = 32'sh8000_0000;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [CNT_W-1:0]          count_type;

endpackage

// File: rtl/sine_taylor_series.sv
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | req_angle (Q3.28 radians)
// rsp     | out       | rsp_valid / rsp_stall  | rsp_sine_value, rsp_saturated
// csr     | in        | csr_write_enable       | csr_write_data (term count)
//
// One request enters per cycle while req_stall is low; a result passes through
// the front stages, then a chain of five-stage term units, one per series term
// after the first, then the output register.
// Reset clears all valid bits, drops rsp_valid and sets the term count to 10.
// While rsp_valid is high and rsp_stall is high, the whole pipeline holds and
// req_stall is high; nothing is dropped or repeated.

module sine_taylor_series #(
   parameter int MAX_TERMS = 10,
   parameter int FRAC_BITS = 28
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  sts_pkg::angle_type  req_angle,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sts_pkg::angle_type  rsp_sine_value,
   output logic                rsp_saturated,
   // configuration
   input  logic                csr_write_enable,
   input  sts_pkg::count_type  csr_write_data
);

   import sts_pkg::*;

   localparam int XSQ_W   = 63 - FRAC_BITS;        // x^2 and factor width
   localparam int FHI_W   = XSQ_W - 32;            // upper slice of x^2 / factor
   localparam int GROUPS  = MAX_TERMS - 1;         // term units
   localparam int FLO_W   = 32 + FRAC_BITS;        // x^2 low slice * reciprocal
   localparam int FHP_W   = FHI_W + FRAC_BITS;     // x^2 high slice * reciprocal
   localparam int THI_W   = TERM_W - 32;           // upper slice of term magnitude
   localparam int P01_W   = 32 + FHI_W;
   localparam int P10_W   = THI_W + 32;
   localparam int P11_W   = THI_W + FHI_W;
   localparam int PROD_W  = TERM_W + XSQ_W;
   localparam logic [63:0]        RND     = 64'd1 << (FRAC_BITS - 1);
   localparam logic [PROD_W-1:0]  RND_P   = PROD_W'(RND);
   localparam logic [XSQ_W-1:0]   XSQ_MAX = XSQ_W'(1) << (62 - FRAC_BITS);
   localparam logic signed [ACC_W:0] SUM_CAP = (ACC_W + 1)'(MAG_CAP);

   // values that travel with each item between term units
   typedef struct packed {
      logic [XSQ_W-1:0]         xsq;
      logic                     tneg;
      logic [TERM_W-1:0]        tmag;
      logic signed [ACC_W-1:0]  acc;
      logic                     ovf;
   } carry_type;

   logic        pipe_en;
   count_type   term_count_ff;
   count_type   term_count_in;
   count_type   cnt_eff;

   // front stages
   logic              s0_v_ff;
   angle_type         s0_angle_ff;
   logic [31:0]       s0_mag_ff;
   logic [31:0]       s0_mag_in;
   logic              s1_v_ff;
   angle_type         s1_angle_ff;
   logic [31:0]       s1_mag_ff;
   logic [63:0]       s1_sq_ff;
   logic [63:0]       s1_sq_in;
   logic [63:0]       s2_sq_rnd;
   carry_type         b0_in;

   // term unit boundaries
   logic       bv_ff [0:GROUPS];
   carry_type  bc_ff [0:GROUPS];

   // output register
   logic                    rsp_valid_ff;
   angle_type               rsp_value_ff;
   logic                    rsp_sat_ff;
   angle_type               rsp_value_in;
   logic                    rsp_sat_in;
   logic signed [ACC_W-1:0] fin_acc;

   // global advance: hold only while a result waits and the receiver stalls
   assign pipe_en   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en;

   // term count register and its effective value
   always_comb begin
      term_count_in = csr_write_enable ? csr_write_data : term_count_ff;
      if (term_count_ff == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (term_count_ff > CNT_W'(MAX_TERMS)) begin
         cnt_eff = CNT_W'(MAX_TERMS);
      end else begin
         cnt_eff = term_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_COUNT_RESET;
      end else begin
         term_count_ff <= term_count_in;
      end
   end

   // stage 0: capture angle and its magnitude
   assign s0_mag_in = req_angle[ANGLE_W-1] ? 32'(-req_angle) : 32'(req_angle);

   // stage 1: square of the magnitude
   assign s1_sq_in = 64'(s0_mag_ff) * 64'(s0_mag_ff);

   // stage 2: round x^2 and seed the series with x
   always_comb begin
      s2_sq_rnd  = s1_sq_ff + RND;
      b0_in.xsq  = XSQ_W'(s2_sq_rnd >> FRAC_BITS);
      b0_in.tneg = s1_angle_ff[ANGLE_W-1];
      b0_in.tmag = TERM_W'(s1_mag_ff);
      b0_in.acc  = ACC_W'(s1_angle_ff);
      b0_in.ovf  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         bv_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         s0_v_ff  <= req_valid;
         s1_v_ff  <= s0_v_ff;
         bv_ff[0] <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_angle_ff <= req_angle;
         s0_mag_ff   <= s0_mag_in;
         s1_angle_ff <= s0_angle_ff;
         s1_mag_ff   <= s0_mag_ff;
         s1_sq_ff    <= s1_sq_in;
         bc_ff[0]    <= b0_in;
      end
   end

   // one five-stage unit per further term
   for (genvar g = 0; g < GROUPS; g++) begin : g_term
      localparam int unsigned DEN = (2 * g + 2) * (2 * g + 3);
      localparam logic [FRAC_BITS-1:0] RECIP =
         FRAC_BITS'(((64'd1 << FRAC_BITS) + DEN / 2) / DEN);

      logic              v1_ff, v2_ff, v3_ff, v4_ff;
      carry_type         c1_ff, c2_ff, c3_ff, c4_ff;
      logic [FLO_W-1:0]  fa_lo_ff, fa_lo_in;
      logic [FHP_W-1:0]  fa_hi_ff, fa_hi_in;
      logic [63:0]       fsum;
      logic [XSQ_W-1:0]  fac_ff, fac_in;
      logic [63:0]       pp00_ff, pp00_in;
      logic [P01_W-1:0]  pp01_ff, pp01_in;
      logic [P10_W-1:0]  pp10_ff, pp10_in;
      logic [P11_W-1:0]  pp11_ff, pp11_in;
      logic [PROD_W-1:0] prod, rnd;
      logic [TERM_W-1:0] mag_ff, mag_in;
      logic              big_ff, big_in;
      logic              active;
      logic              nneg;
      logic signed [ACC_W:0] tval, sum;
      carry_type         out_in;

      // S1: x^2 times reciprocal, two partial products
      assign fa_lo_in = FLO_W'(bc_ff[g].xsq[31:0]) * FLO_W'(RECIP);
      assign fa_hi_in = FHP_W'(bc_ff[g].xsq[XSQ_W-1:32]) * FHP_W'(RECIP);

      // S2: factor = round(x^2 * recip)
      always_comb begin
         fsum   = 64'(fa_lo_ff) + (64'(fa_hi_ff) << 32) + RND;
         fac_in = XSQ_W'(fsum >> FRAC_BITS);
      end

      // S3: term magnitude times factor, four partial products
      assign pp00_in = 64'(c2_ff.tmag[31:0]) * 64'(fac_ff[31:0]);
      assign pp01_in = P01_W'(c2_ff.tmag[31:0]) * P01_W'(fac_ff[XSQ_W-1:32]);
      assign pp10_in = P10_W'(c2_ff.tmag[TERM_W-1:32]) * P10_W'(fac_ff[31:0]);
      assign pp11_in = P11_W'(c2_ff.tmag[TERM_W-1:32]) * P11_W'(fac_ff[XSQ_W-1:32]);

      // S4: combine, round, cap the magnitude
      always_comb begin
         prod   = PROD_W'(pp00_ff) + (PROD_W'(pp01_ff) << 32)
                + (PROD_W'(pp10_ff) << 32) + (PROD_W'(pp11_ff) << 64) + RND_P;
         rnd    = prod >> FRAC_BITS;
         big_in = |rnd[PROD_W-1:TERM_W];
         mag_in = big_in ? MAG_CAP : rnd[TERM_W-1:0];
      end

      // S5: flip sign, accumulate with clamp; idle units pass through
      always_comb begin
         active = cnt_eff > CNT_W'(g + 1);
         nneg   = !c4_ff.tneg;
         tval   = nneg ? -$signed({2'b00, mag_ff}) : $signed({2'b00, mag_ff});
         sum    = (ACC_W + 1)'(c4_ff.acc) + tval;
         out_in = c4_ff;
         if (active) begin
            out_in.tneg = nneg;
            out_in.tmag = mag_ff;
            out_in.ovf  = c4_ff.ovf | big_ff;
            if (sum > SUM_CAP) begin
               out_in.acc = ACC_W'(SUM_CAP);
               out_in.ovf = 1'b1;
            end else if (sum < -SUM_CAP) begin
               out_in.acc = ACC_W'(-SUM_CAP);
               out_in.ovf = 1'b1;
            end else begin
               out_in.acc = ACC_W'(sum);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v1_ff        <= 1'b0;
            v2_ff        <= 1'b0;
            v3_ff        <= 1'b0;
            v4_ff        <= 1'b0;
            bv_ff[g + 1] <= 1'b0;
         end else if (pipe_en) begin
            v1_ff        <= bv_ff[g];
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            v4_ff        <= v3_ff;
            bv_ff[g + 1] <= v4_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            c1_ff        <= bc_ff[g];
            fa_lo_ff     <= fa_lo_in;
            fa_hi_ff     <= fa_hi_in;
            c2_ff        <= c1_ff;
            fac_ff       <= fac_in;
            c3_ff        <= c2_ff;
            pp00_ff      <= pp00_in;
            pp01_ff      <= pp01_in;
            pp10_ff      <= pp10_in;
            pp11_ff      <= pp11_in;
            c4_ff        <= c3_ff;
            mag_ff       <= mag_in;
            big_ff       <= big_in;
            bc_ff[g + 1] <= out_in;
         end
      end
   end

   // final clip to 32 bits
   always_comb begin
      fin_acc      = bc_ff[GROUPS].acc;
      rsp_sat_in   = bc_ff[GROUPS].ovf;
      rsp_value_in = ANGLE_W'(fin_acc);
      if (bc_ff[GROUPS].ovf) begin
         rsp_value_in = fin_acc[ACC_W-1] ? OUT_MIN : OUT_MAX;
      end else if (fin_acc > ACC_OUT_MAX) begin
         rsp_value_in = OUT_MAX;
         rsp_sat_in   = 1'b1;
      end else if (fin_acc < ACC_OUT_MIN) begin
         rsp_value_in = OUT_MIN;
         rsp_sat_in   = 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= bv_ff[GROUPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sine_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // a clipped result is always one of the two rails
   a_sat_rails : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |-> rsp_value_ff == OUT_MAX || rsp_value_ff == OUT_MIN)
      else $error("saturated result not at a rail");

   // running sum never reaches the most negative value of its width
   a_acc_range : assert property (@(posedge clock) disable iff (reset)
      bv_ff[GROUPS] |-> !(bc_ff[GROUPS].acc[ACC_W-1] && bc_ff[GROUPS].acc[ACC_W-2:0] == '0))
      else $error("accumulator outside capped range");

   // rounded x^2 stays within its bound
   a_xsq_bound : assert property (@(posedge clock) disable iff (reset)
      bv_ff[0] |-> bc_ff[0].xsq <= XSQ_MAX)
      else $error("x squared exceeds bound");

   // a stalled waiting result freezes the last boundary
   a_hold_tail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(bv_ff[GROUPS]) && $stable(bc_ff[GROUPS]))
      else $error("pipeline advanced while output stalled");

endmodule

// File: dv/tb_sine_taylor_series.sv
`timescale 1ns / 1ps

module tb_sine_taylor_series;

   import sts_pkg::*;

   localparam int MAX_TERMS      = 10;
   localparam int FRAC_BITS      = 28;
   localparam int RAND_PER_PHASE = 78;
   localparam int DRAIN_CYCLES   = 60;
   localparam int IDLE_LIMIT     = 4000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct {
      angle_type angle;
      count_type terms;
      angle_type sine;
      logic      sat;
   } sine_result_type;

   logic      clock            = 1'b0;
   logic      reset            = 1'b1;
   logic      req_valid        = 1'b0;
   logic      req_stall;
   angle_type req_angle        = '0;
   logic      rsp_valid;
   logic      rsp_stall        = 1'b0;
   angle_type rsp_sine_value;
   logic      rsp_saturated;
   logic      csr_write_enable = 1'b0;
   count_type csr_write_data   = '0;

   // pending requests and predicted results
   angle_type       angle_queue[$];
   sine_result_type sine_expect[$];
   count_type       term_count_model = TERM_COUNT_RESET;

   int error_count     = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int saturated_seen  = 0;
   int settings_run    = 0;
   int burst_left      = 0;
   int gap_left        = 0;
   int idle_cycles     = 0;
   int stall_timer     = 0;
   stall_mode_type stall_mode = STALL_NONE;

   angle_type directed_angles[$] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h1000_0000, 32'hF000_0000, 32'h1921_FB54, 32'hE6DE_04AC, 32'h3243_F6A9,
      32'hCDBC_0957, 32'h4000_0000, 32'hC000_0000, 32'h6000_0000, 32'h0000_0080,
      32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_8000, 32'h5555_5555, 32'hAAAA_AAAA
   };

   sine_taylor_series #(
      .MAX_TERMS(MAX_TERMS),
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_angle(req_angle),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sine_value(rsp_sine_value),
      .rsp_saturated(rsp_saturated),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // signed fixed-point multiply: rounded magnitudes, capped at 2^62-1
   function automatic longint fx_mul(input longint a, input longint b, inout bit ovf);
      bit           neg;
      logic [63:0]  ma, mb;
      logic [127:0] mag;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? 64'(-a) : 64'(a);
      mb  = (b < 0) ? 64'(-b) : 64'(b);
      mag = ((128'(ma) * 128'(mb)) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (mag > 128'(MAG_CAP)) begin
         mag = 128'(MAG_CAP);
         ovf = 1'b1;
      end
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   // truncated series with reciprocal-constant division and output clipping
   function automatic sine_result_type predict_sine(input angle_type ang,
                                                    input count_type cnt);
      sine_result_type r;
      longint          x, x_sq, term, acc, recip, factor, d, cap;
      int              n;
      bit              ovf;
      cap = longint'(MAG_CAP);
      ovf = 1'b0;
      n   = int'(cnt);
      if (n == 0) n = 1;
      if (n > MAX_TERMS) n = MAX_TERMS;
      x    = longint'(ang);
      x_sq = fx_mul(x, x, ovf);
      term = x;
      acc  = x;
      for (int i = 0; i + 1 < n; i++) begin
         d      = longint'((2 * i + 2) * (2 * i + 3));
         recip  = ((64'sd1 <<< FRAC_BITS) + d / 2) / d;
         factor = fx_mul(x_sq, recip, ovf);
         term   = -fx_mul(term, factor, ovf);
         acc    = acc + term;
         if (acc > cap) begin
            acc = cap;
            ovf = 1'b1;
         end else if (acc < -cap) begin
            acc = -cap;
            ovf = 1'b1;
         end
      end
      if (ovf) begin
         acc = (acc >= 0) ? longint'(OUT_MAX) : longint'(OUT_MIN);
      end else if (acc > longint'(OUT_MAX)) begin
         acc = longint'(OUT_MAX);
         ovf = 1'b1;
      end else if (acc < longint'(OUT_MIN)) begin
         acc = longint'(OUT_MIN);
         ovf = 1'b1;
      end
      r.angle = ang;
      r.terms = cnt;
      r.sine  = acc[31:0];
      r.sat   = ovf;
      return r;
   endfunction

   // mostly in-range angles, plus full-range noise and the clipping region
   function automatic angle_type pick_angle();
      int unsigned pi_q;
      pi_q = 32'h3243_F6A9;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return angle_type'($urandom_range(0, 2 * pi_q) - pi_q);
         4, 5, 6:    return angle_type'($urandom);
         7:          return $urandom_range(0, 1) ? OUT_MAX - angle_type'($urandom_range(0, 255))
                                                 : OUT_MIN + angle_type'($urandom_range(0, 255));
         8:          return angle_type'($urandom_range(0, 511)) - 32'sd256;
         default:    return $urandom_range(0, 1) ? angle_type'($urandom_range(32'h2800_0000,
                                                                            32'h4800_0000))
                                                 : -angle_type'($urandom_range(32'h2800_0000,
                                                                               32'h4800_0000));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // register writes only happen with the pipeline empty
   task automatic write_term_count(input count_type value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      term_count_model = value;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (angle_queue.size() != 0 || req_valid || sine_expect.size() != 0);
   endtask

   task automatic run_phase(input count_type value, input bit directed);
      if (!directed) write_term_count(value);
      if (directed) begin
         foreach (directed_angles[i]) angle_queue.push_back(directed_angles[i]);
      end
      angle_queue.push_back(OUT_MAX);
      angle_queue.push_back(OUT_MIN);
      angle_queue.push_back('0);
      angle_queue.push_back(32'h1921_FB54);
      repeat (RAND_PER_PHASE) angle_queue.push_back(pick_angle());
      wait_drained();
      settings_run++;
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            sine_expect.push_back(predict_sine(req_angle, term_count_model));
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (angle_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_angle <= angle_queue.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall: the mode changes whenever its random timer runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_mode  = STALL_NONE;
         stall_timer = 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode  = stall_mode_type'($urandom_range(0, 3));
            stall_timer = $urandom_range(40, 300);
         end else begin
            stall_timer--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (stall_timer % 7) < 3;
         endcase
      end
   end

   // response monitor: compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sine_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected result sine=%h sat=%b",
                                      rsp_sine_value, rsp_saturated));
         end else begin
            automatic sine_result_type want = sine_expect.pop_front();
            if (rsp_sine_value !== want.sine)
               report_mismatch($sformatf("angle=%h terms=%0d sine got %h want %h",
                                         want.angle, want.terms, rsp_sine_value, want.sine));
            if (rsp_saturated !== want.sat)
               report_mismatch($sformatf("angle=%h terms=%0d saturated got %b want %b",
                                         want.angle, want.terms, rsp_saturated, want.sat));
            if (want.sat) saturated_seen++;
         end
         results_checked++;
      end
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("tb_sine_taylor_series: FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // reset term count first, then every register value, then a few random ones
      run_phase(TERM_COUNT_RESET, 1'b1);
      for (int k = 0; k < 16; k++) run_phase(count_type'(k), 1'b0);
      repeat (4) run_phase(count_type'($urandom_range(0, 15)), 1'b0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results over %0d term-count settings",
               requests_sent, results_checked, settings_run);
      $display("%0d results saturated, %0d mismatches", saturated_seen, error_count);
      if (error_count == 0 && sine_expect.size() == 0) begin
         $display("tb_sine_taylor_series: PASS");
      end else begin
         if (sine_expect.size() != 0)
            $display("%0d predicted results never arrived", sine_expect.size());
         $display("tb_sine_taylor_series: FAIL");
      end
      $finish;
   end

endmodule
